FILE: design/ppwr_pkg.sv
`timescale 1ns / 1ps
package ppwr_pkg;

  localparam int PORTS_DEFAULT       = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 32;

  localparam logic [31:0] CHECK_INTERVAL_RST   = 32'd10000;
  localparam logic [31:0] HOLDOFF_TIME_RST     = 32'd60000;
  localparam logic [31:0] RESTART_OFF_TIME_RST = 32'd5000;
  localparam logic [31:0] SESSION_TIMEOUT_RST  = 32'd300000;
  localparam logic [7:0]  ERROR_LIMIT_RST      = 8'd3;
  localparam logic [7:0]  FAIL_COUNT_MAX       = 8'hFF;

  typedef enum logic [1:0] {
    MODE_SESSION = 2'd0,
    MODE_PASS    = 2'd1,
    MODE_PORT    = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    RLY_NONE = 2'd0,
    RLY_OFF  = 2'd1,
    RLY_ON   = 2'd2
  } relay_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHECK_INTERVAL   = 3'd0,
    CFG_HOLDOFF_TIME     = 3'd1,
    CFG_RESTART_OFF_TIME = 3'd2,
    CFG_SESSION_TIMEOUT  = 3'd3,
    CFG_ERROR_LIMIT      = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } bk_state_e;

  // input beat
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_time;
    logic [2:0]  port_index;
    logic        relay_enabled;
    logic        port_configured;
    logic        ping_ok;
  } item_t;

  // result beat
  typedef struct packed {
    logic [1:0] relay_command;
    logic       check_taken;
    logic       watchdog_running;
    logic       port_restarting;
  } result_t;

  // classified command, front to back
  typedef struct packed {
    mode_e       op;
    logic [31:0] now;
    logic [2:0]  port;      // zero when out of range
    logic        in_range;
    logic        active;    // relay enabled and port configured
    logic        ping_ok;
  } cmd_t;

  // per-port timing entry kept in RAM
  typedef struct packed {
    logic [31:0] last_check;
    logic [31:0] hold_stamp;
    logic [7:0]  fail_count;
  } entry_t;

endpackage

FILE: design/ppwr_ram.sv
`timescale 1ns / 1ps
module ppwr_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                  wdata_i,
  input  logic                          re_i,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                  rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: design/ppwr_front.sv
`timescale 1ns / 1ps
module ppwr_front import ppwr_pkg::*; #(
  parameter int PORTS = PORTS_DEFAULT
) (
  input  logic  start_i,
  input  item_t item_i,
  input  logic  q_full_i,
  output logic  push_o,
  output cmd_t  cmd_o,
  output logic  busy_o
);
  logic [7:0] pidx_ext;
  logic       in_range;

  assign pidx_ext = {5'b0, item_i.port_index};
  assign in_range = (pidx_ext < 8'(PORTS));

  assign busy_o = q_full_i;
  assign push_o = start_i & ~q_full_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.now      = item_i.now_time;
    cmd_o.ping_ok  = item_i.ping_ok;
    case (item_i.mode)
      MODE_SESSION: cmd_o.op = MODE_SESSION;
      MODE_PASS:    cmd_o.op = MODE_PASS;
      MODE_PORT: begin
        cmd_o.op       = MODE_PORT;
        cmd_o.in_range = in_range;
        cmd_o.port     = in_range ? item_i.port_index : 3'd0;
        cmd_o.active   = item_i.relay_enabled & item_i.port_configured;
      end
      default:      cmd_o.op = MODE_NOP;
    endcase
  end
endmodule

FILE: design/ppwr_queue.sv
`timescale 1ns / 1ps
module ppwr_queue import ppwr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic empty_o,
  output logic full_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end
endmodule

FILE: design/ppwr_back.sv
`timescale 1ns / 1ps
module ppwr_back import ppwr_pkg::*; #(
  parameter int PORTS = PORTS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  cmd_t                  head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  output result_t               res_o
);
  localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int EW = $bits(entry_t);

  bk_state_e state_q, state_d;
  logic      exec_en;

  // configuration
  logic [31:0] chk_int_q, holdoff_q, off_time_q, sess_to_q;
  logic [7:0]  err_lim_q;

  // global and per-port flags
  logic             sess_vld_q, sess_vld_d;
  logic [31:0]      sess_stamp_q, sess_stamp_d;
  logic             run_q, run_d;
  logic [PORTS-1:0] rp_q, rp_d, ro_q, ro_d, hv_q, hv_d, ent_vld_q;

  cmd_t          cur_q;
  logic [7:0]    head_ext, cur_ext;
  logic [PW-1:0] raddr, cur_addr;
  logic [EW-1:0] ram_rdata;
  entry_t        ent, ent_d;
  logic          ent_we;

  logic    res_valid_q;
  result_t res_q, res_d;

  assign head_ext = {5'b0, head_i.port};
  assign cur_ext  = {5'b0, cur_q.port};
  assign raddr    = head_ext[PW-1:0];
  assign cur_addr = cur_ext[PW-1:0];

  ppwr_ram #(
    .W (EW),
    .D (PORTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (cur_addr),
    .wdata_i (ent_d),
    .re_i    (pop_o),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // never-written entries read as zero
  assign ent = ent_vld_q[cur_addr] ? entry_t'(ram_rdata) : '0;

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!empty_i) state_d = BK_EXEC;
      BK_EXEC: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    pop_o   = 1'b0;
    exec_en = 1'b0;
    case (state_q)
      BK_IDLE: pop_o   = ~empty_i;
      BK_EXEC: exec_en = 1'b1;
      default: ;
    endcase
  end

  // item execution
  always_comb begin
    logic [31:0] el_hold, el_chk, el_sess;
    logic [7:0]  fc_inc;
    logic        eval, blocked, due, limit_hit;
    logic        rp, ro, hv;

    el_hold = cur_q.now - ent.hold_stamp;
    el_chk  = cur_q.now - ent.last_check;
    el_sess = cur_q.now - sess_stamp_q;
    rp      = rp_q[cur_addr];
    ro      = ro_q[cur_addr];
    hv      = hv_q[cur_addr];
    fc_inc  = (ent.fail_count < FAIL_COUNT_MAX) ? ent.fail_count + 8'd1 : ent.fail_count;

    sess_vld_d   = sess_vld_q;
    sess_stamp_d = sess_stamp_q;
    run_d        = run_q;
    rp_d         = rp_q;
    ro_d         = ro_q;
    hv_d         = hv_q;
    ent_d        = ent;
    ent_we       = 1'b0;
    res_d        = '0;
    blocked      = 1'b0;
    due          = 1'b0;
    limit_hit    = 1'b0;
    eval         = exec_en && cur_q.op == MODE_PORT && cur_q.in_range && run_q && cur_q.active;

    if (exec_en && cur_q.op == MODE_SESSION) begin
      sess_vld_d   = 1'b1;
      sess_stamp_d = cur_q.now;
    end else if (exec_en && cur_q.op == MODE_PASS) begin
      if (sess_vld_q) begin
        if (el_sess >= sess_to_q) sess_vld_d = 1'b0;
        else                      run_d      = |rp_q;
      end else begin
        run_d = 1'b1;
      end
    end

    if (eval) begin
      ent_we  = 1'b1;
      blocked = !rp && hv && (el_hold < holdoff_q);
      if (!blocked) begin
        if (!rp && hv) hv_d[cur_addr] = 1'b0;
        due = (el_chk >= chk_int_q) && !rp;
        if (due) begin
          ent_d.last_check = cur_q.now;
          res_d.check_taken = 1'b1;
          if (!cur_q.ping_ok) begin
            if (fc_inc >= err_lim_q) begin
              // limit reached: only flag the restart this time
              limit_hit        = 1'b1;
              ent_d.fail_count = '0;
              ro_d[cur_addr]   = 1'b0;
              rp_d[cur_addr]   = 1'b1;
            end else begin
              ent_d.fail_count = fc_inc;
            end
          end else begin
            ent_d.fail_count = '0;
          end
        end
        if (!limit_hit && rp) begin
          if (!ro) begin
            ro_d[cur_addr]      = 1'b1;
            hv_d[cur_addr]      = 1'b1;
            ent_d.hold_stamp    = cur_q.now;
            res_d.relay_command = RLY_OFF;
          end else if (el_hold >= off_time_q) begin
            rp_d[cur_addr]      = 1'b0;
            ro_d[cur_addr]      = 1'b0;
            hv_d[cur_addr]      = 1'b1;
            ent_d.hold_stamp    = cur_q.now;
            res_d.relay_command = RLY_ON;
          end
        end
      end
    end

    res_d.watchdog_running = run_d;
    if (cur_q.op == MODE_PORT && cur_q.in_range) res_d.port_restarting = rp_d[cur_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      chk_int_q    <= CHECK_INTERVAL_RST;
      holdoff_q    <= HOLDOFF_TIME_RST;
      off_time_q   <= RESTART_OFF_TIME_RST;
      sess_to_q    <= SESSION_TIMEOUT_RST;
      err_lim_q    <= ERROR_LIMIT_RST;
      sess_vld_q   <= 1'b0;
      sess_stamp_q <= '0;
      run_q        <= 1'b0;
      rp_q         <= '0;
      ro_q         <= '0;
      hv_q         <= '0;
      ent_vld_q    <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sess_vld_q   <= sess_vld_d;
      sess_stamp_q <= sess_stamp_d;
      run_q        <= run_d;
      rp_q         <= rp_d;
      ro_q         <= ro_d;
      hv_q         <= hv_d;
      res_valid_q  <= exec_en;
      if (ent_we) ent_vld_q[cur_addr] <= 1'b1;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CHECK_INTERVAL:   chk_int_q  <= cfg_wdata_i;
          CFG_HOLDOFF_TIME:     holdoff_q  <= cfg_wdata_i;
          CFG_RESTART_OFF_TIME: off_time_q <= cfg_wdata_i;
          CFG_SESSION_TIMEOUT:  sess_to_q  <= cfg_wdata_i;
          CFG_ERROR_LIMIT:      err_lim_q  <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    if (exec_en) res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
endmodule

FILE: design/port_ping_watchdog_restarter_top.sv
`timescale 1ns / 1ps
// Per-port ping watchdog that power-cycles a port after repeated ping failures.
// Input channel: drive item_i and raise start_i; the beat is taken at an edge
// where start_i is high and busy_o is low. item_i.mode picks a session packet,
// a pass start (decides whether the watchdog runs), a port evaluation or a no-op.
// Result channel: res_valid_o is high for exactly one cycle with res_o; the
// receiver cannot stall, so every result must be captured in that cycle.
// Config: cfg_we_i with cfg_idx_i / cfg_wdata_i writes one register per edge
// (0 check interval, 1 hold-off, 2 relay-off time, 3 session timeout,
// 4 error limit); write only while the block is idle.
// Path: the accepted beat is written into the queue; the back end pops the
// head while idle, registering it and its per-port RAM entry (registered
// read), executes it in the EXEC state and registers the result. It takes no
// new beat from the queue until the last one has been executed.
// The front stage feeds a QDEPTH-deep queue; busy_o is high while it is full.
// Reset clears all flags, stamps and config to defaults; per-port RAM entries
// read as zero until first written, so no clearing pass is needed.
module port_ping_watchdog_restarter_top import ppwr_pkg::*; #(
  parameter int PORTS  = PORTS_DEFAULT,
  parameter int QDEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  item_t                 item_i,
  output logic                  res_valid_o,
  output result_t               res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);
  logic push, pop, q_empty, q_full;
  cmd_t front_cmd, head_cmd;

  // front: classify and enqueue
  ppwr_front #(
    .PORTS (PORTS)
  ) u_front (
    .start_i  (start_i),
    .item_i   (item_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (front_cmd),
    .busy_o   (busy_o)
  );

  ppwr_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: port table, timers, relay sequencing
  ppwr_back #(
    .PORTS (PORTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );
endmodule

FILE: design/ppwr_checker.sv
`timescale 1ns / 1ps
module ppwr_checker import ppwr_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    res_valid_i,
  input result_t res_i
);
  // back end returns to IDLE after each EXEC, so results are never back to back
  a_res_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |=> !res_valid_i)
    else $error("results in back-to-back cycles");

  a_cmd_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_i.relay_command != RLY_NONE || res_i.check_taken)
      |-> res_i.watchdog_running)
    else $error("port activity while watchdog stopped");

  a_off_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.relay_command == RLY_OFF |-> res_i.port_restarting)
    else $error("relay off without pending restart");

  a_on_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.relay_command == RLY_ON |-> !res_i.port_restarting)
    else $error("relay on left restart pending");

  a_cmd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_i.relay_command <= RLY_ON)
    else $error("illegal relay command code");
endmodule

bind port_ping_watchdog_restarter_top ppwr_checker u_ppwr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);
